// ----- rtl/core/dual_path_linear_densifier_assert.svh -----
// assertion macros for the densifier core
// used by the top level only, no other dependencies
`ifndef DUAL_PATH_LINEAR_DENSIFIER_ASSERT_SVH
`define DUAL_PATH_LINEAR_DENSIFIER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define DPLD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DPLD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/dpld_pkg.sv -----
// package for the densifier: word types, controller states, command and status structs
// no dependencies
`default_nettype none
package dpld_pkg;
	localparam int unsigned StepReset = 13107;

	typedef struct packed {
		logic signed [31:0] ground_x;
		logic signed [31:0] ground_y;
		logic signed [31:0] ground_z;
		logic signed [31:0] air_x;
		logic signed [31:0] air_y;
		logic signed [31:0] air_z;
		logic [30:0]        tether_len;
		logic [63:0]        ground_rot;
		logic [63:0]        air_rot;
		logic               path_end;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] out_ground_x;
		logic signed [31:0] out_ground_y;
		logic signed [31:0] out_ground_z;
		logic signed [31:0] out_air_x;
		logic signed [31:0] out_air_y;
		logic signed [31:0] out_air_z;
		logic [30:0]        out_tether_len;
		logic [63:0]        out_ground_rot;
		logic [63:0]        out_air_rot;
		logic               run_last;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ, ST_SQRT, ST_DIV, ST_START, ST_POINT, ST_END, ST_COMMIT
	} state_t;

	// which output word the datapath loads into the output register
	typedef enum logic [1:0] {
		SEL_START, SEL_POINT, SEL_END
	} sel_t;

	typedef struct packed {
		logic load_in;    // capture accepted word
		logic sq_start;   // start squared lengths
		logic sqrt_start; // start root
		logic div_start;  // start r = root / step
		logic pt_start;   // start interior point divisions
		logic emit;       // load output register
		sel_t sel;
		logic last;       // run_last of the emitted word
		logic commit;     // move current word into previous
	} cmd_t;

	typedef struct packed {
		logic have_prev;
		logic path_end;
		logic sq_done;
		logic interp;     // longer length exceeds step
		logic sqrt_done;
		logic div_done;
		logic pt_done;
		logic last_point; // point index equals r
	} sts_t;
endpackage
`default_nettype wire

// ----- rtl/core/dpld_ctrl.sv -----
// controller state machine of the densifier
// depends on dpld_pkg
`default_nettype none
module dpld_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	input  wire dpld_pkg::sts_t sts,
	output dpld_pkg::cmd_t      cmd,
	output logic                busy
);
	dpld_pkg::state_t state_q, state_d;
	logic out_valid_q;

	// output register is free when empty or being taken
	logic out_free;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpld_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.sel = dpld_pkg::SEL_START;
		in_stall = 1'b1;
		busy = 1'b1;
		unique case (state_q)
			dpld_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				busy = out_valid_q || in_valid;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = dpld_pkg::ST_SQ;
				end
			end
			dpld_pkg::ST_SQ: begin
				if (!sts.have_prev) begin
					state_d = sts.path_end ? dpld_pkg::ST_END : dpld_pkg::ST_COMMIT;
				end else begin
					cmd.sq_start = 1'b1;
					state_d = dpld_pkg::ST_SQRT;
				end
			end
			dpld_pkg::ST_SQRT: begin
				if (sts.sq_done) begin
					if (sts.interp) begin
						cmd.sqrt_start = 1'b1;
					end
					state_d = dpld_pkg::ST_DIV;
				end
			end
			dpld_pkg::ST_DIV: begin
				if (!sts.interp) begin
					state_d = dpld_pkg::ST_START;
				end else if (sts.sqrt_done) begin
					cmd.div_start = 1'b1;
					state_d = dpld_pkg::ST_START;
				end
			end
			dpld_pkg::ST_START: begin
				if ((!sts.interp || sts.div_done) && out_free) begin
					cmd.emit = 1'b1;
					cmd.sel = dpld_pkg::SEL_START;
					cmd.last = !sts.interp && !sts.path_end;
					if (sts.interp) begin
						cmd.pt_start = 1'b1;
						state_d = dpld_pkg::ST_POINT;
					end else begin
						state_d = sts.path_end ? dpld_pkg::ST_END : dpld_pkg::ST_COMMIT;
					end
				end
			end
			dpld_pkg::ST_POINT: begin
				if (sts.pt_done && out_free) begin
					cmd.emit = 1'b1;
					cmd.sel = dpld_pkg::SEL_POINT;
					cmd.last = sts.last_point && !sts.path_end;
					if (sts.last_point) begin
						state_d = sts.path_end ? dpld_pkg::ST_END : dpld_pkg::ST_COMMIT;
					end else begin
						cmd.pt_start = 1'b1;
					end
				end
			end
			dpld_pkg::ST_END: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					cmd.sel = dpld_pkg::SEL_END;
					cmd.last = 1'b1;
					state_d = dpld_pkg::ST_COMMIT;
				end
			end
			dpld_pkg::ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = dpld_pkg::ST_IDLE;
			end
			default: state_d = dpld_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ----- rtl/core/dpld_datapath.sv -----
// datapath of the densifier: waypoint registers, squared lengths, root, divider, lerp
// depends on dpld_pkg
`default_nettype none
module dpld_datapath #(
	parameter int MAX_SUBDIV = 62
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dpld_pkg::in_word_t in_word,
	input  wire logic [30:0]        step_distance,
	input  wire dpld_pkg::cmd_t     cmd,
	output dpld_pkg::sts_t          sts,
	output dpld_pkg::out_word_t     out_word
);
	localparam int RW = $clog2(MAX_SUBDIV + 2);

	dpld_pkg::in_word_t cur_q, prev_q;
	logic have_prev_q;

	// ---------------- squared lengths, one axis a cycle
	logic [2:0]  sq_k_q;
	logic        sq_busy_q;
	logic [65:0] s1_q, s2_q;
	logic [65:0] m1_q, m2_q; // registered products
	logic        m_vld_q;
	logic signed [32:0] dg, da;
	logic [32:0] ag, aa;
	logic [31:0] ag32, aa32;

	always_comb begin
		unique case (sq_k_q[1:0])
			2'd0: begin
				dg = 33'(cur_q.ground_x) - 33'(prev_q.ground_x);
				da = 33'(cur_q.air_x) - 33'(prev_q.air_x);
			end
			2'd1: begin
				dg = 33'(cur_q.ground_y) - 33'(prev_q.ground_y);
				da = 33'(cur_q.air_y) - 33'(prev_q.air_y);
			end
			default: begin
				dg = 33'(cur_q.ground_z) - 33'(prev_q.ground_z);
				da = 33'(cur_q.air_z) - 33'(prev_q.air_z);
			end
		endcase
		ag = dg[32] ? 33'(-dg) : 33'(dg);
		aa = da[32] ? 33'(-da) : 33'(da);
		ag32 = ag[31:0];
		aa32 = aa[31:0];
	end

	// 33x33 square split: (h*2^32 + l)^2, h is one bit
	function automatic logic [65:0] sq33(input logic [32:0] v, input logic [31:0] l);
		logic [65:0] p;
		p = 66'(l) * 66'(l);
		if (v[32]) p = p + {1'b0, l, 33'd0} + {1'b1, 65'd0} - {1'b1, 65'd0} + (66'd1 << 64);
		return p;
	endfunction

	logic [65:0] smax, lim;
	logic        sq_done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			m_vld_q <= 1'b0;
			sq_done_q <= 1'b0;
			sq_k_q <= '0;
		end else begin
			m_vld_q <= sq_busy_q;
			if (cmd.sq_start) begin
				sq_busy_q <= 1'b1;
				sq_k_q <= '0;
				sq_done_q <= 1'b0;
			end else if (sq_busy_q) begin
				sq_k_q <= sq_k_q + 3'd1;
				if (sq_k_q == 3'd2) sq_busy_q <= 1'b0;
			end
			if (m_vld_q && !sq_busy_q) sq_done_q <= 1'b1;
			if (cmd.load_in) sq_done_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		m1_q <= sq33(ag, ag32);
		m2_q <= sq33(aa, aa32);
		if (cmd.sq_start) begin
			s1_q <= '0;
			s2_q <= '0;
		end else if (m_vld_q) begin
			s1_q <= s1_q + m1_q;
			s2_q <= s2_q + m2_q;
		end
	end

	logic [30:0] step;
	assign step = (step_distance == '0) ? 31'd1 : step_distance;
	logic [61:0] lim_q;
	always_ff @(posedge clk) lim_q <= 62'(step) * 62'(step);
	assign smax = (s2_q > s1_q) ? s2_q : s1_q;
	assign lim = 66'(lim_q);

	// ---------------- integer root, one bit a cycle (restoring)
	logic [67:0] rem_q;
	logic [65:0] sv_q;
	logic [33:0] root_q;
	logic [5:0]  rt_n_q;
	logic        rt_busy_q, rt_done_q;
	logic [67:0] rem_sh, trial;
	always_comb begin
		rem_sh = {rem_q[65:0], sv_q[65:64]};
		trial = {32'd0, root_q, 2'b01};
	end
	// 33 bit pairs of the squared sum, one per busy cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_busy_q <= 1'b0;
			rt_done_q <= 1'b0;
			rt_n_q <= '0;
		end else begin
			if (cmd.sqrt_start) begin
				rt_busy_q <= 1'b1;
				rt_done_q <= 1'b0;
				rt_n_q <= 6'd32;
			end else if (rt_busy_q) begin
				rt_n_q <= rt_n_q - 6'd1;
				if (rt_n_q == 6'd0) begin
					rt_busy_q <= 1'b0;
					rt_done_q <= 1'b1;
				end
			end
			if (cmd.load_in) rt_done_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			rem_q <= '0;
			sv_q <= smax;
			root_q <= '0;
		end else if (rt_busy_q) begin
			sv_q <= {sv_q[63:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[32:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[32:0], 1'b0};
			end
		end
	end

	// ---------------- shared restoring divider, one quotient bit a cycle
	// used for root/step and for each interior coordinate
	localparam int DN = 7; // 3 ground, 3 air, tether
	logic [40:0] dnum_q [DN];  // magnitudes
	logic [40:0] drem_q [DN];
	logic [40:0] dquo_q [DN];
	logic [DN-1:0] dneg_q;
	logic [33:0] dden_q;
	logic [5:0]  dv_n_q;
	logic        dv_busy_q, dv_is_r_q, div_done_q, pt_done_q;
	logic [RW-1:0] r_q, j_q;

	logic signed [32:0] pa [DN];
	logic signed [32:0] pb [DN];
	always_comb begin
		pa[0] = 33'(prev_q.ground_x); pb[0] = 33'(cur_q.ground_x);
		pa[1] = 33'(prev_q.ground_y); pb[1] = 33'(cur_q.ground_y);
		pa[2] = 33'(prev_q.ground_z); pb[2] = 33'(cur_q.ground_z);
		pa[3] = 33'(prev_q.air_x);    pb[3] = 33'(cur_q.air_x);
		pa[4] = 33'(prev_q.air_y);    pb[4] = 33'(cur_q.air_y);
		pa[5] = 33'(prev_q.air_z);    pb[5] = 33'(cur_q.air_z);
		pa[6] = $signed({2'b00, prev_q.tether_len});
		pb[6] = $signed({2'b00, cur_q.tether_len});
	end

	// next point index and numerator (b-a)*(j+1), 33x6 bits at the default MAX_SUBDIV
	// first point of a segment follows the r division directly
	logic [RW-1:0] j_next;
	assign j_next = dv_is_r_q ? RW'(1) : RW'(j_q + RW'(1));
	logic signed [32:0] dlt [DN];
	logic [32:0] dmag [DN];
	logic [40:0] dprod [DN];
	always_comb begin
		for (int i = 0; i < DN; i++) begin
			dlt[i] = pb[i] - pa[i];
			dmag[i] = dlt[i][32] ? 33'(-dlt[i]) : 33'(dlt[i]);
			dprod[i] = 41'(dmag[i]) * 41'(j_next);
		end
	end

	logic [RW-1:0] r_sat;
	logic [33:0] rq;
	assign rq = dquo_q[0][33:0];
	assign r_sat = (rq > 34'(MAX_SUBDIV)) ? RW'(MAX_SUBDIV) : RW'(rq);

	logic [41:0] dsh [DN];
	always_comb begin
		for (int i = 0; i < DN; i++) dsh[i] = {drem_q[i], dnum_q[i][40]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			pt_done_q <= 1'b0;
			dv_is_r_q <= 1'b0;
			dv_n_q <= '0;
		end else begin
			if (cmd.div_start) begin
				dv_busy_q <= 1'b1;
				dv_is_r_q <= 1'b1;
				dv_n_q <= 6'd40;
				div_done_q <= 1'b0;
			end else if (cmd.pt_start) begin
				dv_busy_q <= 1'b1;
				dv_is_r_q <= 1'b0;
				dv_n_q <= 6'd40;
				pt_done_q <= 1'b0;
			end else if (dv_busy_q) begin
				dv_n_q <= dv_n_q - 6'd1;
				if (dv_n_q == 6'd0) begin
					dv_busy_q <= 1'b0;
					if (dv_is_r_q) div_done_q <= 1'b1;
					else pt_done_q <= 1'b1;
				end
			end
			if (cmd.emit) pt_done_q <= 1'b0;
			if (cmd.load_in) begin
				div_done_q <= 1'b0;
				pt_done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dnum_q[0] <= 41'(root_q);
			for (int i = 0; i < DN; i++) begin
				drem_q[i] <= '0;
				if (i != 0) dnum_q[i] <= '0;
			end
			dden_q <= 34'(step);
		end else if (cmd.pt_start) begin
			for (int i = 0; i < DN; i++) begin
				dnum_q[i] <= dprod[i];
				drem_q[i] <= '0;
				dneg_q[i] <= dlt[i][32];
			end
			// r is still in the quotient on the first point
			dden_q <= 34'(dv_is_r_q ? r_sat : r_q) + 34'd1;
			j_q <= j_next;
		end else if (dv_busy_q) begin
			for (int i = 0; i < DN; i++) begin
				dnum_q[i] <= {dnum_q[i][39:0], 1'b0};
				if (dsh[i] >= 42'(dden_q)) begin
					drem_q[i] <= 41'(dsh[i] - 42'(dden_q));
					dquo_q[i] <= {dquo_q[i][39:0], 1'b1};
				end else begin
					drem_q[i] <= dsh[i][40:0];
					dquo_q[i] <= {dquo_q[i][39:0], 1'b0};
				end
			end
		end
		if (div_done_q && cmd.pt_start && dv_is_r_q) r_q <= r_sat;
	end

	// interior value a + sign*quotient, always between a and b
	logic signed [32:0] pv [DN];
	always_comb begin
		for (int i = 0; i < DN; i++)
			pv[i] = dneg_q[i] ? 33'(pa[i] - $signed({1'b0, dquo_q[i][31:0]}))
			                  : 33'(pa[i] + $signed({1'b0, dquo_q[i][31:0]}));
	end

	// ---------------- waypoint registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_q <= '0;
		end else if (cmd.commit) begin
			have_prev_q <= !cur_q.path_end;
			prev_q <= cur_q;
		end
	end
	always_ff @(posedge clk) if (cmd.load_in) cur_q <= in_word;

	// ---------------- output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			unique case (cmd.sel)
				dpld_pkg::SEL_POINT: begin
					out_word.out_ground_x <= pv[0][31:0];
					out_word.out_ground_y <= pv[1][31:0];
					out_word.out_ground_z <= pv[2][31:0];
					out_word.out_air_x <= pv[3][31:0];
					out_word.out_air_y <= pv[4][31:0];
					out_word.out_air_z <= pv[5][31:0];
					out_word.out_tether_len <= pv[6][30:0];
					out_word.out_ground_rot <= prev_q.ground_rot;
					out_word.out_air_rot <= prev_q.air_rot;
				end
				dpld_pkg::SEL_END: begin
					out_word.out_ground_x <= cur_q.ground_x;
					out_word.out_ground_y <= cur_q.ground_y;
					out_word.out_ground_z <= cur_q.ground_z;
					out_word.out_air_x <= cur_q.air_x;
					out_word.out_air_y <= cur_q.air_y;
					out_word.out_air_z <= cur_q.air_z;
					out_word.out_tether_len <= cur_q.tether_len;
					out_word.out_ground_rot <= cur_q.ground_rot;
					out_word.out_air_rot <= cur_q.air_rot;
				end
				default: begin
					out_word.out_ground_x <= prev_q.ground_x;
					out_word.out_ground_y <= prev_q.ground_y;
					out_word.out_ground_z <= prev_q.ground_z;
					out_word.out_air_x <= prev_q.air_x;
					out_word.out_air_y <= prev_q.air_y;
					out_word.out_air_z <= prev_q.air_z;
					out_word.out_tether_len <= prev_q.tether_len;
					out_word.out_ground_rot <= prev_q.ground_rot;
					out_word.out_air_rot <= prev_q.air_rot;
				end
			endcase
			out_word.run_last <= cmd.last;
		end
	end

	assign sts.have_prev = have_prev_q;
	assign sts.path_end = cur_q.path_end;
	assign sts.sq_done = sq_done_q;
	assign sts.interp = smax > lim;
	assign sts.sqrt_done = rt_done_q;
	assign sts.div_done = div_done_q;
	assign sts.pt_done = pt_done_q;
	assign sts.last_point = (j_q == (div_done_q && dv_is_r_q ? r_sat : r_q));
endmodule
`default_nettype wire

// ----- rtl/core/dual_path_linear_densifier.sv -----
// densifier top level: step register, controller and datapath
// depends on dpld_pkg, dpld_ctrl, dpld_datapath, dual_path_linear_densifier_assert.svh
//
// channel   dir  handshake        word
// in        in   in_valid/stall   dpld_pkg::in_word_t
// out       out  out_valid/stall  dpld_pkg::out_word_t
// cfg       in   cfg_valid/ready  step_distance, 31 bits
//
// one waypoint at a time: the squared lengths, then the root, then r, then each interior
// point; the root loop and the r division on the divider set the per-segment cost,
// the shared bit-serial divider the per-point cost
// arst_n clears the previous waypoint, the step register (to 0.2) and all control
// out_stall holds the output register and the controller; in_stall is high unless idle
`default_nettype none
`include "dual_path_linear_densifier_assert.svh"
module dual_path_linear_densifier #(
	parameter int MAX_SUBDIV = 62
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire dpld_pkg::in_word_t  in_word,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output dpld_pkg::out_word_t      out_word,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [30:0]         cfg_data
);
	dpld_pkg::cmd_t cmd;
	dpld_pkg::sts_t sts;
	logic busy;

	// step register, written only while idle with the output drained
	logic [30:0] step_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_q <= 31'(dpld_pkg::StepReset);
		else if (cfg_valid && cfg_ready) step_q <= cfg_data;
	end
	assign cfg_ready = !busy;

	// sequencing of one waypoint
	dpld_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.sts, .cmd, .busy
	);

	// arithmetic and waypoint storage
	dpld_datapath #(.MAX_SUBDIV(MAX_SUBDIV)) u_dp (
		.clk, .arst_n, .in_word, .step_distance(step_q), .cmd, .sts, .out_word
	);

	// a word may only be loaded when the output register is free
	`DPLD_ASSERT_IMP(a_emit_free, clk, arst_n, cmd.emit, !out_valid || !out_stall, "emit into full output")
	// a stalled output word holds
	`DPLD_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_word), "stalled word changed")
	// no new waypoint taken while the controller is working
	`DPLD_ASSERT_IMP(a_no_accept_busy, clk, arst_n, cmd.sq_start, in_stall, "accept during work")
endmodule
`default_nettype wire
